[rtl/srf_pkg.sv]
// Shared types and constants for the split frame reassembler.
`timescale 1ns / 1ps
`default_nettype none

package srf_pkg;

   localparam int unsigned DATA_W     = 8;
   localparam int unsigned TAG_W      = 4;
   localparam int unsigned POS_W      = 8;
   localparam int unsigned AGE_W      = 16;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DATA_W-1:0] SPLIT_FLAG = 8'h01;
   localparam logic [DATA_W-1:0] TAG_MASK   = 8'hF0;
   localparam logic [AGE_W-1:0]  TIMEOUT_RESET = 16'd10000;

   typedef enum logic {
      OPCODE_BYTE = 1'b0,
      OPCODE_TICK = 1'b1
   } opcode_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_ABORT   = 1'b1
   } kind_type;

   typedef struct packed {
      logic              is_tick;
      logic              split;
      logic [TAG_W-1:0]  tag;
      logic [DATA_W-1:0] data;
      logic              eof;
   } item_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

endpackage

`default_nettype wire

[rtl/srf_front.sv]
// Front stage: accepts request beats and decodes them into queue items.
`timescale 1ns / 1ps
`default_nettype none

module srf_front
   import srf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_opcode,
   input  wire logic [DATA_W-1:0] req_data_byte,
   input  wire logic              req_end_of_frame,
   input  wire logic              queue_ready,
   output logic                   item_valid,
   output item_type               item
);

   logic     front_vld_ff;
   logic     front_vld_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   assign req_stall  = front_vld_ff && !queue_ready;
   assign accept     = req_valid && !req_stall;
   assign item_valid = front_vld_ff;
   assign item       = item_ff;

   always_comb begin
      item_in.is_tick = (opcode_type'(req_opcode) == OPCODE_TICK);
      item_in.split   = |(req_data_byte & SPLIT_FLAG);
      item_in.tag     = TAG_W'((req_data_byte & TAG_MASK) >> (DATA_W - TAG_W));
      item_in.data    = req_data_byte;
      item_in.eof     = req_end_of_frame;
      if (accept) begin
         front_vld_in = 1'b1;
      end else if (queue_ready) begin
         front_vld_in = 1'b0;
      end else begin
         front_vld_in = front_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

[rtl/srf_queue.sv]
// Short queue that decouples the front stage from the back stage.
`timescale 1ns / 1ps
`default_nettype none

module srf_queue
   import srf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire item_type       wr_item,
   input  wire queue_ctrl_type ctrl,
   output logic                ready,
   output logic                not_empty,
   output item_type            rd_item
);

   item_type            mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign ready     = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = ctrl.push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = ctrl.pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push && !ctrl.pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (!ctrl.push && ctrl.pop) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

[rtl/srf_back.sv]
// Back stage: frame state machine, timeout counter and response register.
`timescale 1ns / 1ps
`default_nettype none

module srf_back
   import srf_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 255
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [AGE_W-1:0]  csr_write_data,
   input  wire logic              item_valid,
   input  wire item_type          item,
   output logic                   item_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_kind,
   output logic [DATA_W-1:0]      rsp_payload,
   output logic                   rsp_packet_start,
   output logic                   rsp_packet_end
);

   typedef enum logic [1:0] {
      MODE_SINGLE  = 2'd0,
      MODE_FIRST   = 2'd1,
      MODE_SECOND  = 2'd2,
      MODE_DISCARD = 2'd3
   } mode_type;

   localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_FRAME);

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              pending_ff, pending_in;
   logic [TAG_W-1:0]  held_tag_ff, held_tag_in;
   logic [AGE_W-1:0]  age_ff, age_in;
   logic [AGE_W-1:0]  timeout_ff, timeout_in;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in;
   logic [DATA_W-1:0] payload_ff, payload_in;
   logic              start_ff, start_in;
   logic              end_ff, end_in;
   logic              has_result;

   assign item_pop         = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload      = payload_ff;
   assign rsp_packet_start = start_ff;
   assign rsp_packet_end   = end_ff;

   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      pending_in  = pending_ff;
      held_tag_in = held_tag_ff;
      age_in      = age_ff;
      timeout_in  = csr_write_enable ? csr_write_data : timeout_ff;
      has_result  = 1'b0;
      kind_in     = KIND_ABORT;
      payload_in  = '0;
      start_in    = 1'b0;
      end_in      = 1'b0;

      if (item.is_tick) begin
         if (pending_ff) begin
            if (age_ff >= timeout_ff) begin
               pending_in = 1'b0;
               age_in     = '0;
               has_result = 1'b1;
            end else begin
               age_in = AGE_W'(age_ff + 1'b1);
            end
         end
      end else if (mode_ff == MODE_DISCARD) begin
         if (item.eof) begin
            pos_in  = '0;
            mode_in = MODE_SINGLE;
         end
      end else if (pos_ff == '0) begin
         if (!item.eof) begin
            if (item.split) begin
               if (pending_ff && (item.tag == held_tag_ff)) begin
                  mode_in = MODE_SECOND;
               end else begin
                  has_result  = pending_ff;
                  mode_in     = MODE_FIRST;
                  held_tag_in = item.tag;
               end
            end else begin
               has_result = pending_ff;
               mode_in    = MODE_SINGLE;
            end
            pending_in = 1'b0;
            age_in     = '0;
            pos_in     = POS_W'(1);
         end
      end else if (pos_ff >= MaxPos) begin
         pending_in = 1'b0;
         age_in     = '0;
         has_result = 1'b1;
         if (item.eof) begin
            pos_in  = '0;
            mode_in = MODE_SINGLE;
         end else begin
            mode_in = MODE_DISCARD;
         end
      end else begin
         has_result = 1'b1;
         kind_in    = KIND_PAYLOAD;
         payload_in = item.data;
         start_in   = (pos_ff == POS_W'(1)) && (mode_ff != MODE_SECOND);
         end_in     = item.eof && (mode_ff != MODE_FIRST);
         pos_in     = POS_W'(pos_ff + 1'b1);
         if (item.eof) begin
            if (mode_ff == MODE_FIRST) begin
               pending_in = 1'b1;
               age_in     = '0;
            end
            pos_in  = '0;
            mode_in = MODE_SINGLE;
         end
      end

      if (item_pop) begin
         rsp_valid_in = has_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SINGLE;
         pos_ff       <= '0;
         pending_ff   <= 1'b0;
         held_tag_ff  <= '0;
         age_ff       <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= KIND_PAYLOAD;
         payload_ff   <= '0;
         start_ff     <= 1'b0;
         end_ff       <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            mode_ff     <= mode_in;
            pos_ff      <= pos_in;
            pending_ff  <= pending_in;
            held_tag_ff <= held_tag_in;
            age_ff      <= age_in;
         end
         if (item_pop && has_result) begin
            kind_ff    <= kind_in;
            payload_ff <= payload_in;
            start_ff   <= start_in;
            end_ff     <= end_in;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/split_frame_reassembler_core.sv]
// Top level of the split frame reassembler: front stage, queue and back stage.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  opcode, data_byte, end_of_frame
//   rsp      out        rsp_valid / rsp_stall  kind, payload, packet_start, packet_end
//   csr      in         csr_write_enable       csr_write_data (timeout_ticks)
//
// One request beat is taken every cycle while req_stall is low; an accepted beat passes
// through the front register and a queue entry before it reaches the response register.
// The rate is set by the back stage, which retires one queued item per cycle
// whenever the response register is empty or being drained.
// Reset is synchronous and clears all control state; timeout_ticks returns to 10000.
// A stalled response holds the back stage, and the queue then fills and stalls requests.
`timescale 1ns / 1ps
`default_nettype none

module split_frame_reassembler_core
   import srf_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 255
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_opcode,
   input  wire logic [DATA_W-1:0] req_data_byte,
   input  wire logic              req_end_of_frame,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_kind,
   output logic [DATA_W-1:0]      rsp_payload,
   output logic                   rsp_packet_start,
   output logic                   rsp_packet_end,
   input  wire logic              csr_write_enable,
   input  wire logic [AGE_W-1:0]  csr_write_data
);

   logic           queue_ready;
   logic           queue_not_empty;
   logic           front_valid;
   item_type       front_item;
   item_type       back_item;
   logic           back_pop;
   queue_ctrl_type queue_ctrl;

   assign queue_ctrl.push = front_valid && queue_ready;
   assign queue_ctrl.pop  = back_pop;

   srf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .queue_ready      (queue_ready),
      .item_valid       (front_valid),
      .item             (front_item)
   );

   srf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_item   (front_item),
      .ctrl      (queue_ctrl),
      .ready     (queue_ready),
      .not_empty (queue_not_empty),
      .rd_item   (back_item)
   );

   srf_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (queue_not_empty),
      .item             (back_item),
      .item_pop         (back_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload      (rsp_payload),
      .rsp_packet_start (rsp_packet_start),
      .rsp_packet_end   (rsp_packet_end)
   );

endmodule

`default_nettype wire
